>>> hdl/mccq_pkg.sv
package mccq_pkg;

  // Fixed field widths of the stream beats
  localparam int CH_MAX    = 6;
  localparam int SAMPLE_W  = 12;
  localparam int CAL_CH_W  = 3;

  // Slave tdata layout, lowest bit first
  localparam int S_DATA_W      = 104;
  localparam int S_CAL_CH_LSB  = CH_MAX * SAMPLE_W;
  localparam int S_ENTRY_LSB   = S_CAL_CH_LSB + CAL_CH_W;
  localparam int S_EXIT_LSB    = S_ENTRY_LSB + SAMPLE_W;
  localparam int S_RISING_BIT  = S_EXIT_LSB + SAMPLE_W;

  // Master tdata layout
  localparam int M_DATA_W      = 8;
  localparam int M_RESULT_W    = CH_MAX + 1;

  // tuser codes on the slave side
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_CAL  = 1'b1;

  // Threshold values after reset
  localparam logic [SAMPLE_W-1:0] ENTRY_RESET = 12'd1023;
  localparam logic [SAMPLE_W-1:0] EXIT_RESET  = 12'd1022;

  // Per-lane control for one accepted beat
  typedef struct packed {
    logic                tick;
    logic                load;
    logic                rising;
    logic [SAMPLE_W-1:0] entry_level;
    logic [SAMPLE_W-1:0] exit_level;
  } lane_ctrl_t;

endpackage

>>> hdl/mccq_lane.sv
module mccq_lane #(
  parameter int WINDOW_LEN  = 10,
  parameter int ACCEPT_MIN  = 8,
  parameter int RELEASE_LEN = 10,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mccq_pkg::lane_ctrl_t          ctrl,
  input  logic [mccq_pkg::SAMPLE_W-1:0] sample,
  output logic                          contact_next
);
  import mccq_pkg::*;

  localparam int CW  = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int WCW = $clog2(WINDOW_LEN + 1);
  localparam int RCW = $clog2(RELEASE_LEN + 1);
  localparam logic [WCW-1:0] WIN_MAX   = WCW'(WINDOW_LEN);
  localparam logic [RCW-1:0] REL_MAX   = RCW'(RELEASE_LEN);
  localparam bit             ACC_REACH = (ACCEPT_MIN <= WINDOW_LEN);
  localparam logic [WCW-1:0] ACC_MIN_W = WCW'(ACCEPT_MIN);

  logic [CW-1:0]  entry_level;
  logic [CW-1:0]  exit_level;
  logic           rising;
  logic [WCW-1:0] evidence_count, evidence_count_next;
  logic [WCW-1:0] window_count, window_count_next;
  logic [RCW-1:0] release_run, release_run_next;
  logic           candidate, candidate_next;
  logic           confirmed, confirmed_next;

  logic [CW-1:0]  s;
  logic           hit_entry;
  logic           hit_evid;

  assign s         = sample[CW-1:0];
  assign hit_entry = rising ? (s >= entry_level) : (s <= entry_level);
  assign hit_evid  = rising ? (s > exit_level) : (s < exit_level);

  always_comb begin
    evidence_count_next = evidence_count;
    window_count_next   = window_count;
    release_run_next    = release_run;
    candidate_next      = candidate;
    confirmed_next      = confirmed;
    if (ctrl.load) begin
      evidence_count_next = '0;
      window_count_next   = '0;
      release_run_next    = '0;
      candidate_next      = 1'b0;
      confirmed_next      = 1'b0;
    end else if (ctrl.tick) begin
      if (!confirmed) begin
        release_run_next = '0;
        if (!candidate && hit_entry) begin
          // entry crossing opens a fresh window
          candidate_next      = 1'b1;
          evidence_count_next = '0;
          window_count_next   = '0;
        end
        if (candidate_next) begin
          if (window_count_next < WIN_MAX) begin
            window_count_next = window_count_next + WCW'(1);
          end
          if (hit_evid && (evidence_count_next < WIN_MAX)) begin
            evidence_count_next = evidence_count_next + WCW'(1);
          end
          if (window_count_next >= WIN_MAX) begin
            confirmed_next      = ACC_REACH && (evidence_count_next >= ACC_MIN_W);
            candidate_next      = confirmed_next;
            evidence_count_next = '0;
            window_count_next   = '0;
          end
        end
      end else begin
        evidence_count_next = '0;
        window_count_next   = '0;
        if (candidate && !hit_evid) begin
          candidate_next = 1'b0;
        end else if (!candidate && hit_entry) begin
          candidate_next = 1'b1;
        end
        if (candidate_next) begin
          release_run_next = '0;
        end else begin
          if (release_run < REL_MAX) begin
            release_run_next = release_run + RCW'(1);
          end
          if (release_run_next >= REL_MAX) begin
            confirmed_next   = 1'b0;
            release_run_next = '0;
          end
        end
      end
    end
  end

  assign contact_next = confirmed_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_level    <= CW'(ENTRY_RESET);
      exit_level     <= CW'(EXIT_RESET);
      rising         <= 1'b1;
      evidence_count <= '0;
      window_count   <= '0;
      release_run    <= '0;
      candidate      <= 1'b0;
      confirmed      <= 1'b0;
    end else begin
      if (ctrl.load) begin
        entry_level <= ctrl.entry_level[CW-1:0];
        exit_level  <= ctrl.exit_level[CW-1:0];
        rising      <= ctrl.rising;
      end
      evidence_count <= evidence_count_next;
      window_count   <= window_count_next;
      release_run    <= release_run_next;
      candidate      <= candidate_next;
      confirmed      <= confirmed_next;
    end
  end

  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    window_count <= WIN_MAX && evidence_count <= WIN_MAX)
    else $error("window counters out of range");

  a_run_only_confirmed: assert property (@(posedge clk) disable iff (rst)
    (release_run != '0) |-> confirmed)
    else $error("release run counting while not in contact");

  a_confirmed_no_window: assert property (@(posedge clk) disable iff (rst)
    confirmed |-> (window_count == '0 && evidence_count == '0))
    else $error("window open while in contact");

  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    ctrl.load |=> (!confirmed && !candidate && release_run == '0))
    else $error("calibration load left qualifier state");

endmodule

>>> hdl/mccq_merge.sv
module mccq_merge #(
  parameter int CHANNELS = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic [CHANNELS-1:0]           contact_next,
  input  logic                          cal_ok,
  output logic                          ready,
  output logic                          m_valid,
  input  logic                          m_ready,
  output logic [mccq_pkg::M_DATA_W-1:0] m_data
);
  import mccq_pkg::*;

  logic [M_RESULT_W-1:0] result;
  logic [M_RESULT_W-1:0] head, head_next;
  logic [M_RESULT_W-1:0] tail, tail_next;
  logic [1:0]            count, count_next;
  logic                  pop;

  // lanes past CHANNELS report no contact
  assign result  = {cal_ok, CH_MAX'(contact_next)};
  assign pop     = m_valid && m_ready;
  assign ready   = (count != 2'd2);
  assign m_valid = (count != 2'd0);
  assign m_data  = M_DATA_W'(head);

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) begin
          head_next = result;
        end else begin
          tail_next = result;
        end
        count_next = count + 2'd1;
      end
      2'b11: begin
        if (count == 2'd1) begin
          head_next = result;
        end else begin
          head_next = tail;
          tail_next = result;
        end
      end
      2'b01: begin
        head_next  = tail;
        count_next = count - 2'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
    head <= head_next;
    tail <= tail_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("result queue overflow");

  a_empty_push_shows: assert property (@(posedge clk) disable iff (rst)
    (push && count == 2'd0) |=> (m_valid && head == $past(result)))
    else $error("result not presented after push into empty queue");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !pop) |=> (count == 2'd2 && $stable(tail)))
    else $error("full queue changed without a pop");

endmodule

>>> hdl/multi_channel_contact_qualifier.sv
// Channel | Dir | Ports                       | Beat contents
// s_axis  | in  | tvalid, tready, tdata, tuser | tick samples or one-leg calibration
// m_axis  | out | tvalid, tready, tdata        | contact mask and calibration status
//
// One beat per cycle while s_axis_tready is high: every lane compares and
// updates its counters in the cycle the input beat is taken, so throughput is
// one item per clock until the queue fills; results are registered in the queue.
// A two-entry result queue sits between the sides; s_axis_tready drops only
// while both entries are held, so m_axis stalls back up after two beats.
// rst (synchronous) loads 1023/1022, rising polarity, clears lanes and queue.
module multi_channel_contact_qualifier #(
  parameter int CHANNELS    = 6,
  parameter int WINDOW_LEN  = 10,
  parameter int ACCEPT_MIN  = 8,
  parameter int RELEASE_LEN = 10,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [71:0] sample_0..sample_5 (12 each), [74:72] cal_channel,
  // [86:75] cal_entry_level, [98:87] cal_exit_level, [99] cal_rising, [103:100] zero
  input  logic [mccq_pkg::S_DATA_W-1:0] s_axis_tdata,
  // [0] kind: 0 tick, 1 calibration
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [5:0] contact_mask, [6] cal_accepted, [7] zero
  output logic [mccq_pkg::M_DATA_W-1:0] m_axis_tdata
);
  import mccq_pkg::*;

  logic                accept;
  logic                is_tick;
  logic                is_cal;
  logic [CAL_CH_W-1:0] cal_channel;
  logic [SAMPLE_W-1:0] cal_entry;
  logic [SAMPLE_W-1:0] cal_exit;
  logic                cal_rising;
  logic                ch_ok;
  logic                order_ok;
  logic                cal_ok;
  logic [CHANNELS-1:0] contact_next;

  assign accept      = s_axis_tvalid && s_axis_tready;
  assign is_tick     = accept && (s_axis_tuser == KIND_TICK);
  assign is_cal      = accept && (s_axis_tuser == KIND_CAL);

  assign cal_channel = s_axis_tdata[S_CAL_CH_LSB +: CAL_CH_W];
  assign cal_entry   = s_axis_tdata[S_ENTRY_LSB +: SAMPLE_W];
  assign cal_exit    = s_axis_tdata[S_EXIT_LSB +: SAMPLE_W];
  assign cal_rising  = s_axis_tdata[S_RISING_BIT];

  // Hysteresis order: rising wants exit below entry, falling wants it above.
  // Checked on the full 12-bit values before any masking.
  assign ch_ok    = (32'(cal_channel) < CHANNELS);
  assign order_ok = cal_rising ? (cal_exit < cal_entry) : (cal_exit > cal_entry);
  assign cal_ok   = is_cal && ch_ok && order_ok;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    lane_ctrl_t ctrl;

    assign ctrl.tick        = is_tick;
    assign ctrl.load        = cal_ok && (cal_channel == CAL_CH_W'(i));
    assign ctrl.rising      = cal_rising;
    assign ctrl.entry_level = cal_entry;
    assign ctrl.exit_level  = cal_exit;

    mccq_lane #(
      .WINDOW_LEN  (WINDOW_LEN),
      .ACCEPT_MIN  (ACCEPT_MIN),
      .RELEASE_LEN (RELEASE_LEN),
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .sample       (s_axis_tdata[i*SAMPLE_W +: SAMPLE_W]),
      .contact_next (contact_next[i])
    );
  end

  // Merge the lane flags into the result beat and queue it
  mccq_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk          (clk),
    .rst          (rst),
    .push         (accept),
    .contact_next (contact_next),
    .cal_ok       (cal_ok),
    .ready        (s_axis_tready),
    .m_valid      (m_axis_tvalid),
    .m_ready      (m_axis_tready),
    .m_data       (m_axis_tdata)
  );

endmodule
